### rtl/stpu_pkg.sv
// Shared types and constants for the software timer pool unit.
`timescale 1ns / 1ps
`default_nettype none
package stpu_pkg;

    localparam int SLOTS_DEF  = 3;
    localparam int TICKS_W    = 16;
    localparam int HANDLE_W   = 8;
    localparam int SLOT_OUT_W = 3;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_STOP  = 2'd2,
        KIND_LOAD  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_INVALID  = 2'd3
    } t_status;

    // One slot entry as held in the slot RAM.
    typedef struct packed {
        logic [HANDLE_W-1:0] owner;
        logic [TICKS_W-1:0]  period;
        logic [TICKS_W-1:0]  remaining;
        logic                reload;
    } t_slot;

    // Result fields that are settled while an item is worked on.
    typedef struct packed {
        t_status               status;
        logic                  expired;
        logic [HANDLE_W-1:0]   expired_handle;
        logic [SLOT_OUT_W-1:0] slot_index;
    } t_res;

endpackage
`default_nettype wire

### rtl/stpu_in_if.sv
// Input channel of the timer pool: one command beat.
`timescale 1ns / 1ps
`default_nettype none
interface stpu_in_if;
    logic                          valid;
    logic                          ready;
    stpu_pkg::t_kind               kind;
    logic [stpu_pkg::TICKS_W-1:0]  ticks;
    logic                          repeat_req;
    logic [stpu_pkg::HANDLE_W-1:0] handle;

    modport source (output valid, output kind, output ticks, output repeat_req,
                    output handle, input ready);
    modport sink   (input valid, input kind, input ticks, input repeat_req,
                    input handle, output ready);
endinterface
`default_nettype wire

### rtl/stpu_out_if.sv
// Output channel of the timer pool: one result beat.
`timescale 1ns / 1ps
`default_nettype none
interface stpu_out_if;
    logic                            valid;
    logic                            ready;
    stpu_pkg::t_status               status;
    logic                            expired;
    logic [stpu_pkg::HANDLE_W-1:0]   expired_handle;
    logic [stpu_pkg::SLOT_OUT_W-1:0] slot_index;
    logic                            delay_busy;
    logic                            last;

    modport source (output valid, output status, output expired, output expired_handle,
                    output slot_index, output delay_busy, output last, input ready);
    modport sink   (input valid, input status, input expired, input expired_handle,
                    input slot_index, input delay_busy, input last, output ready);
endinterface
`default_nettype wire

### rtl/software_timer_pool_unit.sv
// Top level of the software timer pool unit: command decode, slot walk, result buffer.
`timescale 1ns / 1ps
`default_nettype none
// Pool of SLOTS timer slots plus one delay countdown. Commands arrive one beat at a
// time on i_item: tick, start, stop, or delay load. Start claims the lowest free slot
// (status FULL if none), stop frees the lowest active slot with a matching handle
// (status NOTFOUND if none); handle 0 is rejected with status INVALID. A tick
// decrements the delay counter if nonzero and every active slot; each slot that hits
// zero produces one expiry beat in slot order, then reloads or frees itself. A tick
// with no expiry gives a single plain beat. The final beat of each command has last
// set, and delay_busy reflects the delay counter after the command.
// Timing: one command at a time. Start, load and rejected commands are accepted, then
// give their result. Tick and stop walk the slot RAM: accept, skip each free slot, do a
// RAM read then an update/write-back for each active slot, and hand over the final
// beat; a stop ends at its match. The walk is set by the single read port and single
// decrementer on the slot RAM. Output backpressure adds stall cycles whenever a beat
// (an expiry beat during the walk, or the final beat) must leave while the result
// register is still full.
// No clearing pass after reset: slot activity lives in flops that reset clears.
module software_timer_pool_unit #(
    parameter int SLOTS = stpu_pkg::SLOTS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    stpu_in_if.sink    i_item,
    stpu_out_if.source o_result
);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_SCAN_RD = 4'b0010,
        S_SCAN_EX = 4'b0100,
        S_EMIT    = 4'b1000
    } t_state;

    // Control
    t_state                              r_state, n_state;
    logic [SLOTS-1:0]                    r_active, n_active;
    logic [IDX_W-1:0]                    r_idx, n_idx;
    logic                                r_is_tick, n_is_tick;
    logic [stpu_pkg::HANDLE_W-1:0]       r_handle, n_handle;
    logic [stpu_pkg::TICKS_W-1:0]        r_delay, n_delay;

    // Pending result: held back until we know whether it is the final beat
    stpu_pkg::t_res                      r_pend, n_pend;
    logic                                r_pend_vld, n_pend_vld;

    // Output register
    stpu_pkg::t_res                      r_out;
    logic                                r_out_last;
    logic                                r_out_busy;
    logic                                r_out_valid;

    // RAM port signals
    logic                                wr_en;
    logic [IDX_W-1:0]                    wr_addr;
    stpu_pkg::t_slot                     wr_data;
    logic                                rd_en;
    stpu_pkg::t_slot                     rd_data;

    logic                                accept;
    logic                                out_free;
    logic                                push;
    logic                                push_last;
    logic                                adv;
    logic                                any_free;
    logic [IDX_W-1:0]                    free_idx;
    logic [stpu_pkg::TICKS_W-1:0]        rem;
    stpu_pkg::t_slot                     upd;

    stpu_slot_ram #(
        .SLOTS(SLOTS)
    ) u_slot_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_idx),
        .o_rd_data(rd_data)
    );

    assign i_item.ready = (r_state == S_IDLE);
    assign accept       = i_item.valid && (r_state == S_IDLE);
    assign out_free     = !r_out_valid || o_result.ready;

    // Lowest free slot
    always_comb begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                any_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign rem = rd_data.remaining - stpu_pkg::TICKS_W'(1);

    always_comb begin
        upd            = rd_data;
        upd.remaining  = (rem == '0 && rd_data.reload) ? rd_data.period : rem;
    end

    always_comb begin
        n_state    = r_state;
        n_active   = r_active;
        n_idx      = r_idx;
        n_is_tick  = r_is_tick;
        n_handle   = r_handle;
        n_delay    = r_delay;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        wr_en      = 1'b0;
        wr_addr    = r_idx;
        wr_data    = upd;
        rd_en      = 1'b0;
        push       = 1'b0;
        push_last  = 1'b0;
        adv        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pend     = '{status: stpu_pkg::ST_OK, expired: 1'b0,
                                   expired_handle: '0, slot_index: '0};
                    n_pend_vld = 1'b0;
                    n_idx      = '0;
                    n_handle   = i_item.handle;
                    n_state    = S_EMIT;
                    case (i_item.kind)
                        stpu_pkg::KIND_TICK: begin
                            if (r_delay != '0) begin
                                n_delay = r_delay - stpu_pkg::TICKS_W'(1);
                            end
                            n_is_tick = 1'b1;
                            n_state   = S_SCAN_RD;
                        end
                        stpu_pkg::KIND_START: begin
                            if (i_item.handle == '0) begin
                                n_pend.status = stpu_pkg::ST_INVALID;
                            end else if (!any_free) begin
                                n_pend.status = stpu_pkg::ST_FULL;
                            end else begin
                                wr_en                = 1'b1;
                                wr_addr              = free_idx;
                                wr_data.owner        = i_item.handle;
                                wr_data.period       = i_item.ticks;
                                wr_data.remaining    = i_item.ticks;
                                wr_data.reload       = i_item.repeat_req;
                                n_active[free_idx]   = 1'b1;
                                n_pend.slot_index    = stpu_pkg::SLOT_OUT_W'(free_idx);
                            end
                        end
                        stpu_pkg::KIND_STOP: begin
                            if (i_item.handle == '0) begin
                                n_pend.status = stpu_pkg::ST_INVALID;
                            end else begin
                                n_is_tick = 1'b0;
                                n_state   = S_SCAN_RD;
                            end
                        end
                        stpu_pkg::KIND_LOAD: begin
                            n_delay = i_item.ticks;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN_RD: begin
                if (r_active[r_idx]) begin
                    rd_en   = 1'b1;
                    n_state = S_SCAN_EX;
                end else begin
                    adv = 1'b1;
                end
            end

            S_SCAN_EX: begin
                if (r_is_tick) begin
                    if (rem == '0) begin
                        // Expiry: previous pending beat leaves first, not final
                        if (!r_pend_vld || out_free) begin
                            push       = r_pend_vld;
                            n_pend     = '{status: stpu_pkg::ST_OK, expired: 1'b1,
                                           expired_handle: rd_data.owner,
                                           slot_index: stpu_pkg::SLOT_OUT_W'(r_idx)};
                            n_pend_vld = 1'b1;
                            wr_en      = 1'b1;
                            if (!rd_data.reload) begin
                                n_active[r_idx] = 1'b0;
                            end
                            adv = 1'b1;
                        end
                    end else begin
                        wr_en = 1'b1;
                        adv   = 1'b1;
                    end
                end else begin
                    if (rd_data.owner == r_handle) begin
                        n_active[r_idx]   = 1'b0;
                        n_pend.slot_index = stpu_pkg::SLOT_OUT_W'(r_idx);
                        n_state           = S_EMIT;
                    end else begin
                        adv = 1'b1;
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (adv) begin
            if (r_idx == LAST_IDX) begin
                n_state = S_EMIT;
                if (!r_is_tick) begin
                    n_pend.status = stpu_pkg::ST_NOTFOUND;
                end
            end else begin
                n_idx   = r_idx + IDX_W'(1);
                n_state = S_SCAN_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_delay     <= '0;
            r_pend_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_active   <= n_active;
            r_delay    <= n_delay;
            r_pend_vld <= n_pend_vld;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_is_tick <= n_is_tick;
        r_handle  <= n_handle;
        r_pend    <= n_pend;
        if (push) begin
            r_out      <= r_pend;
            r_out_last <= push_last;
            r_out_busy <= (r_delay != '0);
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.status         = r_out.status;
    assign o_result.expired        = r_out.expired;
    assign o_result.expired_handle = r_out.expired_handle;
    assign o_result.slot_index     = r_out.slot_index;
    assign o_result.delay_busy     = r_out_busy;
    assign o_result.last           = r_out_last;

endmodule
`default_nettype wire

### rtl/stpu_slot_ram.sv
// Slot RAM: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module stpu_slot_ram #(
    parameter  int SLOTS = stpu_pkg::SLOTS_DEF,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_wr_en,
    input  wire logic [IDX_W-1:0]                i_wr_addr,
    input  wire stpu_pkg::t_slot                 i_wr_data,
    input  wire logic                            i_rd_en,
    input  wire logic [IDX_W-1:0]                i_rd_addr,
    output      stpu_pkg::t_slot                 o_rd_data
);
    stpu_pkg::t_slot r_mem [SLOTS];
    stpu_pkg::t_slot r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule
`default_nettype wire

### rtl/stpu_checker.sv
// Port-level assertions for the timer pool unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module stpu_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_out_valid,
    input wire logic                            i_out_ready,
    input wire stpu_pkg::t_status               i_out_status,
    input wire logic                            i_out_expired,
    input wire logic [stpu_pkg::HANDLE_W-1:0]   i_out_expired_handle,
    input wire logic [stpu_pkg::SLOT_OUT_W-1:0] i_out_slot_index,
    input wire logic                            i_out_last
);
    // Stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status) &&
        $stable(i_out_expired_handle) && $stable(i_out_slot_index) && $stable(i_out_last))
        else $error("result beat changed while stalled");

    // Expiry beats carry a live owner and ok status
    a_exp_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_expired |->
        i_out_status == stpu_pkg::ST_OK && i_out_expired_handle != '0)
        else $error("expiry beat without owner handle or with error status");

    a_noexp_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_expired |-> i_out_expired_handle == '0 && i_out_last)
        else $error("plain beat has a handle or is not final");

    // Rejected commands report slot 0 in a single beat
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != stpu_pkg::ST_OK |->
        i_out_slot_index == '0 && i_out_last && !i_out_expired)
        else $error("error beat with slot index or not final");

endmodule

bind software_timer_pool_unit stpu_checker u_stpu_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_out_valid         (o_result.valid),
    .i_out_ready         (o_result.ready),
    .i_out_status        (o_result.status),
    .i_out_expired       (o_result.expired),
    .i_out_expired_handle(o_result.expired_handle),
    .i_out_slot_index    (o_result.slot_index),
    .i_out_last          (o_result.last)
);
`default_nettype wire

### sim/software_timer_pool_unit_test.sv
// Self-checking testbench for the software timer pool unit: driver, monitor, predictor.
`timescale 1ns / 1ps
`default_nettype none
// Commands are queued up front: a short directed list, then random traffic.
// The directed list covers rejected handles, a full pool, a missing handle, duplicate
// handles, zero and maximum periods, one-shot and repeating slots, and delay loads.
// The random traffic is about half ticks, with starts, stops and delay loads mixed in.
// Periods are kept short so that slots expire often. Stops mostly name a recently
// started handle, so that slots get freed again.
// A negedge driver feeds the queue into the block. A posedge monitor runs each accepted
// command through a local model of the pool and checks every result beat, in order,
// against the expected beats.
module software_timer_pool_unit_test;

    localparam int SLOTS     = stpu_pkg::SLOTS_DEF;
    localparam int TICKS_W   = stpu_pkg::TICKS_W;
    localparam int HANDLE_W  = stpu_pkg::HANDLE_W;
    localparam int SLOT_W    = stpu_pkg::SLOT_OUT_W;
    localparam int N_RANDOM  = 500;
    // The limit is far past the worst tick, which walks every slot and may hold three beats.
    localparam int STALL_MAX = 4000;
    localparam int TAIL_CYC  = 24;
    localparam int SHOW_MAX  = 10;

    typedef struct packed {
        stpu_pkg::t_kind      kind;
        logic [TICKS_W-1:0]   ticks;
        logic                 rep;
        logic [HANDLE_W-1:0]  handle;
        logic                 drain;    // hold this command until no result is outstanding
    } t_cmd;

    typedef struct packed {
        stpu_pkg::t_status     status;
        logic                  expired;
        logic [HANDLE_W-1:0]   exp_handle;
        logic [SLOT_W-1:0]     slot;
        logic                  busy;
        logic                  last;
    } t_beat;

    logic i_clk;
    logic i_rst_n;

    stpu_in_if  cmd_if ();
    stpu_out_if res_if ();

    software_timer_pool_unit #(
        .SLOTS(SLOTS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (cmd_if),
        .o_result(res_if)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Local copy of the pool state.
    logic [HANDLE_W-1:0] pool_owner  [SLOTS];
    logic [TICKS_W-1:0]  pool_period [SLOTS];
    logic [TICKS_W-1:0]  pool_left   [SLOTS];
    logic                pool_repeat [SLOTS];
    logic [TICKS_W-1:0]  delay_left;

    t_cmd  cmd_backlog [$];
    t_beat due_beats   [$];

    int   cmds_total;
    int   cmds_in;
    int   beats_out;
    int   expiries;
    int   rejects;
    int   mismatches;
    int   stall;
    logic cmd_taken;
    logic calm;

    // Window of commands with no idling on either side.
    assign calm = (cmds_in >= 200) && (cmds_in < 330);

    function automatic logic idle_now();
        return !calm && ($urandom_range(99) < 12);
    endfunction

    function automatic void queue_cmd(stpu_pkg::t_kind k, logic [TICKS_W-1:0] t,
                                      logic rp, logic [HANDLE_W-1:0] h,
                                      logic dr = 1'b0);
        t_cmd c;
        c.kind   = k;
        c.ticks  = t;
        c.rep    = rp;
        c.handle = h;
        c.drain  = dr;
        cmd_backlog.push_back(c);
    endfunction

    // delay_busy always shows the delay counter as it stands after the command.
    function automatic t_beat beat_of(stpu_pkg::t_status s, logic x,
                                      logic [HANDLE_W-1:0] h, int slot, logic fin);
        t_beat b;
        b.status     = s;
        b.expired    = x;
        b.exp_handle = h;
        b.slot       = SLOT_W'(slot);
        b.busy       = (delay_left != '0);
        b.last       = fin;
        return b;
    endfunction

    // Applies one command to the local pool and queues the beats it must produce.
    function automatic void pool_advance(input t_cmd c);
        t_beat fired [SLOTS];
        int    n;
        int    hit;
        n   = 0;
        hit = -1;
        case (c.kind)
            stpu_pkg::KIND_TICK: begin
                if (delay_left != '0) delay_left = delay_left - TICKS_W'(1);
                // Count wraps, so a zero period runs the full 65536 ticks.
                for (int i = 0; i < SLOTS; i++) begin
                    if (pool_owner[i] != '0) begin
                        pool_left[i] = pool_left[i] - TICKS_W'(1);
                        if (pool_left[i] == '0) begin
                            fired[n] = beat_of(stpu_pkg::ST_OK, 1'b1, pool_owner[i],
                                               i, 1'b0);
                            if (pool_repeat[i]) pool_left[i] = pool_period[i];
                            else pool_owner[i] = '0;
                            n++;
                        end
                    end
                end
                if (n == 0)
                    due_beats.push_back(beat_of(stpu_pkg::ST_OK, 1'b0, '0, 0, 1'b1));
                for (int k = 0; k < n; k++) begin
                    fired[k].last = (k == n - 1);
                    due_beats.push_back(fired[k]);
                end
            end
            stpu_pkg::KIND_START: begin
                if (c.handle == '0) begin
                    due_beats.push_back(beat_of(stpu_pkg::ST_INVALID, 1'b0, '0, 0, 1'b1));
                end else begin
                    for (int i = 0; i < SLOTS; i++)
                        if (hit < 0 && pool_owner[i] == '0) hit = i;
                    if (hit < 0) begin
                        due_beats.push_back(beat_of(stpu_pkg::ST_FULL, 1'b0, '0, 0, 1'b1));
                    end else begin
                        pool_owner[hit]  = c.handle;
                        pool_period[hit] = c.ticks;
                        pool_left[hit]   = c.ticks;
                        pool_repeat[hit] = c.rep;
                        due_beats.push_back(beat_of(stpu_pkg::ST_OK, 1'b0, '0, hit, 1'b1));
                    end
                end
            end
            stpu_pkg::KIND_STOP: begin
                if (c.handle == '0) begin
                    due_beats.push_back(beat_of(stpu_pkg::ST_INVALID, 1'b0, '0, 0, 1'b1));
                end else begin
                    // Duplicates: only the lowest matching slot is freed.
                    for (int i = 0; i < SLOTS; i++)
                        if (hit < 0 && pool_owner[i] == c.handle) hit = i;
                    if (hit < 0) begin
                        due_beats.push_back(beat_of(stpu_pkg::ST_NOTFOUND, 1'b0, '0, 0,
                                                    1'b1));
                    end else begin
                        pool_owner[hit] = '0;
                        due_beats.push_back(beat_of(stpu_pkg::ST_OK, 1'b0, '0, hit, 1'b1));
                    end
                end
            end
            default: begin
                delay_left = c.ticks;
                due_beats.push_back(beat_of(stpu_pkg::ST_OK, 1'b0, '0, 0, 1'b1));
            end
        endcase
    endfunction

    // Driver: everything changes on the falling edge. A command that has been put
    // on the bus stays there until it is taken.
    always @(negedge i_clk) begin
        t_cmd nxt;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= !idle_now();
            if (!cmd_if.valid || cmd_taken) begin
                if (cmd_backlog.size() == 0 || idle_now()) begin
                    cmd_if.valid <= 1'b0;
                end else if (cmd_backlog[0].drain && due_beats.size() != 0) begin
                    cmd_if.valid <= 1'b0;     // wait until every result is out
                end else begin
                    nxt = cmd_backlog.pop_front();
                    cmd_if.kind       <= nxt.kind;
                    cmd_if.ticks      <= nxt.ticks;
                    cmd_if.repeat_req <= nxt.rep;
                    cmd_if.handle     <= nxt.handle;
                    cmd_if.valid      <= 1'b1;
                end
            end
        end
    end

    // Monitor: checks result beats and feeds accepted commands to the predictor.
    // Results are checked before the new command is predicted: one command is in
    // the block at a time, so a beat seen now always belongs to an earlier command.
    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        t_cmd  seen;
        cmd_taken <= cmd_if.valid && cmd_if.ready;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got.status     = res_if.status;
                got.expired    = res_if.expired;
                got.exp_handle = res_if.expired_handle;
                got.slot       = res_if.slot_index;
                got.busy       = res_if.delay_busy;
                got.last       = res_if.last;
                beats_out++;
                if (got.expired) expiries++;
                if (got.status != stpu_pkg::ST_OK) rejects++;
                if (due_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("%0t: beat with nothing expected: status=%0d exp=%0b",
                                 $realtime, got.status, got.expired,
                                 " handle=%02h slot=%0d busy=%0b last=%0b",
                                 got.exp_handle, got.slot, got.busy, got.last);
                end else begin
                    want = due_beats.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= SHOW_MAX) begin
                            $display("%0t: beat %0d mismatch", $realtime, beats_out);
                            $display("  expected status=%0d exp=%0b handle=%02h slot=%0d",
                                     want.status, want.expired, want.exp_handle, want.slot,
                                     " busy=%0b last=%0b", want.busy, want.last);
                            $display("  actual   status=%0d exp=%0b handle=%02h slot=%0d",
                                     got.status, got.expired, got.exp_handle, got.slot,
                                     " busy=%0b last=%0b", got.busy, got.last);
                        end
                    end
                end
            end
            if (cmd_if.valid && cmd_if.ready) begin
                seen.kind   = cmd_if.kind;
                seen.ticks  = cmd_if.ticks;
                seen.rep    = cmd_if.repeat_req;
                seen.handle = cmd_if.handle;
                seen.drain  = 1'b0;
                pool_advance(seen);
                cmds_in++;
            end
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) stall = 0;
            else stall++;
        end
    end

    // Watchdog: too long without any beat on either side.
    initial begin
        wait (stall >= STALL_MAX);
        $display("timeout: no beat accepted for %0d cycles", STALL_MAX);
        $display("software_timer_pool_unit_test: done, errors");
        $finish;
    end

    initial begin
        int                  r;
        int                  lo;
        logic                dr;
        logic [HANDLE_W-1:0] h;
        logic [TICKS_W-1:0]  period;
        logic [HANDLE_W-1:0] started [$];

        i_rst_n           = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.kind       = stpu_pkg::KIND_TICK;
        cmd_if.ticks      = '0;
        cmd_if.repeat_req = 1'b0;
        cmd_if.handle     = '0;
        res_if.ready      = 1'b0;
        cmd_taken         = 1'b0;
        cmds_in           = 0;
        beats_out         = 0;
        expiries          = 0;
        rejects           = 0;
        mismatches        = 0;
        stall             = 0;
        delay_left        = '0;
        for (int i = 0; i < SLOTS; i++) begin
            pool_owner[i]  = '0;
            pool_period[i] = '0;
            pool_left[i]   = '0;
            pool_repeat[i] = 1'b0;
        end

        // Directed list.
        queue_cmd(stpu_pkg::KIND_TICK,  '0,       1'b0, '0);     // empty pool, delay idle
        queue_cmd(stpu_pkg::KIND_STOP,  '0,       1'b0, '0);     // stop with handle zero
        queue_cmd(stpu_pkg::KIND_START, 16'd5,    1'b1, '0);     // start with handle zero
        queue_cmd(stpu_pkg::KIND_STOP,  '0,       1'b0, 8'h05);  // handle not in pool
        queue_cmd(stpu_pkg::KIND_LOAD,  16'd2,    1'b0, '0);
        queue_cmd(stpu_pkg::KIND_START, 16'd1,    1'b1, 8'hFF);  // slot 0, fires every tick
        queue_cmd(stpu_pkg::KIND_START, 16'd2,    1'b0, 8'h01);  // slot 1, one-shot
        queue_cmd(stpu_pkg::KIND_START, 16'd0,    1'b0, 8'hFF);  // slot 2, zero period, dup
        queue_cmd(stpu_pkg::KIND_START, 16'hFFFF, 1'b1, 8'h07);  // pool full
        queue_cmd(stpu_pkg::KIND_TICK,  '0,       1'b0, '0);     // slot 0 fires
        queue_cmd(stpu_pkg::KIND_TICK,  '0,       1'b0, '0);     // slots 0, 1 fire, delay out
        queue_cmd(stpu_pkg::KIND_START, 16'hFFFF, 1'b1, 8'hAA);  // reuses freed slot 1
        queue_cmd(stpu_pkg::KIND_STOP,  '0,       1'b0, 8'hFF);  // lowest duplicate only
        queue_cmd(stpu_pkg::KIND_TICK,  '0,       1'b0, '0);     // zero-period slot 2 still counting after its wrap
        queue_cmd(stpu_pkg::KIND_STOP,  '0,       1'b0, 8'hFF);
        queue_cmd(stpu_pkg::KIND_STOP,  '0,       1'b0, 8'hFF);  // already gone
        queue_cmd(stpu_pkg::KIND_LOAD,  16'hFFFF, 1'b1, 8'hFF);
        queue_cmd(stpu_pkg::KIND_LOAD,  '0,       1'b0, '0);
        queue_cmd(stpu_pkg::KIND_START, 16'd3,    1'b0, 8'h03);
        queue_cmd(stpu_pkg::KIND_START, 16'd3,    1'b1, 8'h04);
        queue_cmd(stpu_pkg::KIND_START, 16'd1,    1'b0, 8'h09);  // full again
        queue_cmd(stpu_pkg::KIND_TICK,  '0,       1'b0, '0);
        queue_cmd(stpu_pkg::KIND_TICK,  '0,       1'b0, '0);
        queue_cmd(stpu_pkg::KIND_TICK,  '0,       1'b0, '0);     // two expiries in one tick
        queue_cmd(stpu_pkg::KIND_STOP,  '0,       1'b0, 8'hAA);
        queue_cmd(stpu_pkg::KIND_STOP,  '0,       1'b0, 8'h04);

        // Random traffic, tick heavy, with short periods so that expiries are common.
        for (int n = 0; n < N_RANDOM; n++) begin
            r  = $urandom_range(99);
            dr = (n == 0) || (n == N_RANDOM / 2);
            if ($urandom_range(19) == 0) h = '0;
            else if ($urandom_range(9) == 0) h = HANDLE_W'($urandom);
            else h = HANDLE_W'($urandom_range(6, 1));
            if (r < 48) begin
                queue_cmd(stpu_pkg::KIND_TICK, TICKS_W'($urandom), 1'($urandom),
                          HANDLE_W'($urandom), dr);
            end else if (r < 72) begin
                case ($urandom_range(39))
                    0:       period = '0;
                    1, 2:    period = TICKS_W'($urandom);
                    default: period = TICKS_W'($urandom_range(8, 1));
                endcase
                queue_cmd(stpu_pkg::KIND_START, period, 1'($urandom), h, dr);
                if (h != '0) started.push_back(h);
            end else if (r < 90) begin
                // Mostly one of the last few started handles.
                if (started.size() != 0 && $urandom_range(3) != 0) begin
                    lo = (started.size() > 6) ? started.size() - 6 : 0;
                    h  = started[$urandom_range(started.size() - 1, lo)];
                end
                queue_cmd(stpu_pkg::KIND_STOP, TICKS_W'($urandom), 1'($urandom), h, dr);
            end else begin
                if ($urandom_range(2) == 0) period = TICKS_W'($urandom);
                else period = TICKS_W'($urandom_range(12));
                queue_cmd(stpu_pkg::KIND_LOAD, period, 1'($urandom),
                          HANDLE_W'($urandom), dr);
            end
        end
        cmds_total = cmd_backlog.size();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Counters move on the rising edge, so look at them on the falling one.
        @(negedge i_clk);
        while (cmds_in != cmds_total || due_beats.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);

        $display("covered %0d commands on %0d slots: %0d result beats, %0d expiries,",
                 cmds_in, SLOTS, beats_out, expiries);
        $display("  %0d rejected commands, %0d mismatches", rejects, mismatches);
        if (mismatches == 0 && due_beats.size() == 0)
            $display("software_timer_pool_unit_test: done, clean");
        else
            $display("software_timer_pool_unit_test: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
